### rtl/tsjf_pkg.sv
// Shared types and constants for the touch sample jump filter queue.
package tsjf_pkg;

  // Configuration port
  localparam int CFG_DATA_W = 16;
  localparam logic CFG_JUMP_MAX = 1'b0;
  localparam logic CFG_SKIP_MAX = 1'b1;

  localparam logic [15:0] JUMP_MAX_RST = 16'd900;
  localparam logic [3:0]  SKIP_MAX_RST = 4'd3;

  // Opcodes
  localparam logic [1:0] OP_REPORT  = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_SPARE   = 2'd3;

  // Controller status codes
  localparam logic [6:0] CODE_RELEASE = 7'h00;
  localparam logic [7:0] HIGH_RELEASE = 8'h00;
  localparam logic [6:0] CODE_PRESS   = 7'h30;
  localparam logic [7:0] HIGH_PRESS   = 8'h0c;

  // Result status codes
  localparam logic [2:0] ST_QUEUED    = 3'd0;
  localparam logic [2:0] ST_DROPPED   = 3'd1;
  localparam logic [2:0] ST_JUMP      = 3'd2;
  localparam logic [2:0] ST_BAD       = 3'd3;
  localparam logic [2:0] ST_NOT_OURS  = 3'd4;
  localparam logic [2:0] ST_OTHER     = 3'd5;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  stat_lo;
    logic [7:0]  stat_hi;
    logic [15:0] sample_x;
    logic [15:0] sample_y;
    logic [62:0] timestamp;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  report_status;
    logic        event_valid;
    logic [62:0] event_time;
    logic [15:0] event_x;
    logic [15:0] event_y;
    logic        event_pressed;
  } out_word_t;

  // Work handed from the front to the back
  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_NOTE = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [2:0]  status;
    logic [62:0] ev_time;
    logic [15:0] ev_x;
    logic [15:0] ev_y;
    logic        ev_pressed;
  } cmd_word_t;

  // One ring entry
  typedef struct packed {
    logic [62:0] ev_time;
    logic        ev_pressed;
    logic [15:0] ev_y;
    logic [15:0] ev_x;
  } ev_entry_t;

endpackage

### rtl/tsjf_front.sv
// Front end: takes words, runs the jump filter and emits back-end commands.
module tsjf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  input  tsjf_pkg::in_word_t  in_data,
  input  logic                cmd_ready,
  output logic                cmd_push,
  output tsjf_pkg::cmd_word_t cmd
);

  logic [15:0] jump_max;
  logic [3:0]  skip_max;
  logic [3:0]  skip_count;
  logic [3:0]  skip_count_next;
  logic [15:0] last_x;
  logic [15:0] last_y;
  logic        last_load;
  logic [15:0] dx;
  logic [15:0] dy;
  logic        jump;
  logic        filt_active;

  assign cmd_push = in_valid && cmd_ready;

  // Per-axis distance from the last accepted press
  assign dx = (in_data.sample_x >= last_x) ? (in_data.sample_x - last_x)
                                           : (last_x - in_data.sample_x);
  assign dy = (in_data.sample_y >= last_y) ? (in_data.sample_y - last_y)
                                           : (last_y - in_data.sample_y);
  assign jump = (dx > jump_max) || (dy > jump_max);
  assign filt_active = (skip_count != 4'd0) && (skip_count <= skip_max);

  // Classify the word
  always_comb begin
    cmd.kind        = tsjf_pkg::CMD_NOTE;
    cmd.status      = tsjf_pkg::ST_OTHER;
    cmd.ev_time     = in_data.timestamp;
    cmd.ev_x        = in_data.sample_x;
    cmd.ev_y        = in_data.sample_y;
    cmd.ev_pressed  = 1'b1;
    skip_count_next = skip_count;
    last_load       = 1'b0;
    unique case (in_data.opcode)
      tsjf_pkg::OP_REPORT: begin
        if (!in_data.stat_lo[7]) begin
          cmd.status = tsjf_pkg::ST_NOT_OURS;
        end else if (in_data.stat_lo[6:0] == tsjf_pkg::CODE_RELEASE &&
                     in_data.stat_hi == tsjf_pkg::HIGH_RELEASE) begin
          cmd.kind       = tsjf_pkg::CMD_PUSH;
          cmd.ev_x       = 16'd0;
          cmd.ev_y       = 16'd0;
          cmd.ev_pressed = 1'b0;
        end else if (in_data.stat_lo[6:0] == tsjf_pkg::CODE_PRESS &&
                     in_data.stat_hi == tsjf_pkg::HIGH_PRESS) begin
          if (filt_active && jump) begin
            cmd.status      = tsjf_pkg::ST_JUMP;
            skip_count_next = skip_count + 4'd1;
          end else begin
            cmd.kind        = tsjf_pkg::CMD_PUSH;
            skip_count_next = 4'd1;
            last_load       = 1'b1;
          end
        end else begin
          cmd.status = tsjf_pkg::ST_BAD;
        end
      end
      tsjf_pkg::OP_READ: begin
        cmd.kind = tsjf_pkg::CMD_POP;
      end
      tsjf_pkg::OP_RELEASE: begin
        skip_count_next = 4'd0;
      end
      default: begin
        cmd.status = tsjf_pkg::ST_OTHER;
      end
    endcase
  end

  // Filter state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      jump_max   <= tsjf_pkg::JUMP_MAX_RST;
      skip_max   <= tsjf_pkg::SKIP_MAX_RST;
      skip_count <= 4'd0;
      last_x     <= 16'd0;
      last_y     <= 16'd0;
    end else begin
      if (cfg_we && cfg_index == tsjf_pkg::CFG_JUMP_MAX) begin
        jump_max <= cfg_data;
      end
      if (cfg_we && cfg_index == tsjf_pkg::CFG_SKIP_MAX) begin
        skip_max <= cfg_data[3:0];
      end
      if (cmd_push) begin
        skip_count <= skip_count_next;
        if (last_load) begin
          last_x <= in_data.sample_x;
          last_y <= in_data.sample_y;
        end
      end
    end
  end

endmodule

### rtl/tsjf_cmd_fifo.sv
// Two-entry command queue between the front and back ends.
module tsjf_cmd_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tsjf_pkg::cmd_word_t push_data,
  output logic                push_ready,
  input  logic                pop,
  output logic                pop_valid,
  output tsjf_pkg::cmd_word_t pop_data
);

  tsjf_pkg::cmd_word_t q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = q[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/tsjf_back.sv
// Back end: event ring memory, push/pop execution and the result register.
module tsjf_back #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  tsjf_pkg::cmd_word_t cmd,
  output logic                cmd_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output tsjf_pkg::out_word_t out_data
);

  localparam int IDX_W = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_READ = 2'b10
  } bk_state_t;

  bk_state_t state;
  bk_state_t state_next;

  tsjf_pkg::ev_entry_t mem [QUEUE_DEPTH];
  tsjf_pkg::ev_entry_t rd_data;
  tsjf_pkg::ev_entry_t wr_entry;
  logic                mem_we;
  logic                mem_re;

  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx_next;
  logic [IDX_W-1:0] rd_idx_next;
  logic [IDX_W-1:0] wr_inc;
  logic [IDX_W-1:0] rd_inc;

  tsjf_pkg::out_word_t res_next;
  logic                res_load;
  logic                out_free;

  assign wr_inc   = (wr_idx == LAST_IDX) ? '0 : wr_idx + 1'b1;
  assign rd_inc   = (rd_idx == LAST_IDX) ? '0 : rd_idx + 1'b1;
  assign out_free = !out_valid || out_ready;

  assign wr_entry.ev_time    = cmd.ev_time;
  assign wr_entry.ev_pressed = cmd.ev_pressed;
  assign wr_entry.ev_y       = cmd.ev_y;
  assign wr_entry.ev_x       = cmd.ev_x;

  // Command execution
  always_comb begin
    state_next   = state;
    cmd_pop      = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    wr_idx_next  = wr_idx;
    rd_idx_next  = rd_idx;
    res_load     = 1'b0;
    res_next     = '0;
    res_next.report_status = tsjf_pkg::ST_OTHER;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            tsjf_pkg::CMD_PUSH: begin
              mem_we      = 1'b1;
              wr_idx_next = wr_inc;
              res_load    = 1'b1;
              if (wr_inc == rd_idx) begin
                rd_idx_next            = rd_inc;
                res_next.report_status = tsjf_pkg::ST_DROPPED;
              end else begin
                res_next.report_status = tsjf_pkg::ST_QUEUED;
              end
            end
            tsjf_pkg::CMD_POP: begin
              if (rd_idx != wr_idx) begin
                mem_re      = 1'b1;
                rd_idx_next = rd_inc;
                state_next  = BK_READ;
              end else begin
                res_load = 1'b1;
              end
            end
            default: begin
              res_load               = 1'b1;
              res_next.report_status = cmd.status;
            end
          endcase
        end
      end
      BK_READ: begin
        if (out_free) begin
          res_load               = 1'b1;
          res_next.event_valid   = 1'b1;
          res_next.event_time    = rd_data.ev_time;
          res_next.event_x       = rd_data.ev_x;
          res_next.event_y       = rd_data.ev_y;
          res_next.event_pressed = rd_data.ev_pressed;
          state_next             = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Ring memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= wr_entry;
    end
    if (mem_re) begin
      rd_data <= mem[rd_idx];
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data <= res_next;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      wr_idx    <= '0;
      rd_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      wr_idx <= wr_idx_next;
      rd_idx <= rd_idx_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/touch_sample_jump_filter_queue.sv
// Touch sample jump filter with event ring: a word is taken in every cycle
// while the two-entry command queue has room; the front end classifies it
// and runs the jump filter in that cycle. The back end executes one command
// per cycle while the result register is free (report, release confirm,
// empty read); a read that pops an event also waits in the read state,
// as the ring memory read is registered. Commands are registered in the
// queue and results in the result register; a stalled result stalls the
// back end, and after two more words the input side stalls too. The ring
// holds QUEUE_DEPTH-1 events; pushing into a full ring drops the oldest.
// No clearing pass is needed after reset.
module touch_sample_jump_filter_queue #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  tsjf_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tsjf_pkg::out_word_t out_data
);

  tsjf_pkg::cmd_word_t front_cmd;
  tsjf_pkg::cmd_word_t back_cmd;
  logic                front_push;
  logic                back_valid;
  logic                back_pop;

  // Front end
  tsjf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cmd_ready (in_ready),
    .cmd_push  (front_push),
    .cmd       (front_cmd)
  );

  // Command queue
  tsjf_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (front_push),
    .push_data  (front_cmd),
    .push_ready (in_ready),
    .pop        (back_pop),
    .pop_valid  (back_valid),
    .pop_data   (back_cmd)
  );

  // Back end
  tsjf_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd       (back_cmd),
    .cmd_pop   (back_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/tsjf_checker.sv
// Port-level checks for the touch sample jump filter queue, bound to the top.
module tsjf_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input tsjf_pkg::out_word_t out_data
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Popped events only come from reads
  a_event_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.event_valid |->
      out_data.report_status == tsjf_pkg::ST_OTHER)
    else $error("popped event with wrong status");

  // Event fields are zero unless an event was popped
  a_event_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.event_valid |->
      out_data.event_time == 63'd0 && out_data.event_x == 16'd0 &&
      out_data.event_y == 16'd0 && !out_data.event_pressed)
    else $error("event fields set without an event");

  // Status code range
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.report_status <= tsjf_pkg::ST_OTHER)
    else $error("status code out of range");

endmodule

bind touch_sample_jump_filter_queue tsjf_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### tb/sv/touch_sample_jump_filter_queue_tb.sv
// Testbench for the touch sample jump filter queue: directed and random words, scoreboard.
module touch_sample_jump_filter_queue_tb;

  localparam int RING_DEPTH  = 64;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 4;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic                cfg_index = 1'b0;
  logic [15:0]         cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  tsjf_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  tsjf_pkg::out_word_t out_data;

  // Stimulus waiting for the driver and results waiting for the DUT
  tsjf_pkg::in_word_t  touch_cmds[$];
  tsjf_pkg::out_word_t outcome_queue[$];
  int        queued_count = 0;
  int        accepted_count = 0;
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        send_gap_pct = 11;
  int        recv_stall_pct = 57;

  // Predictor state
  logic [62:0] ring_time[RING_DEPTH];
  logic [32:0] ring_pos[RING_DEPTH];
  int          wr_ptr = 0;
  int          rd_ptr = 0;
  logic [3:0]  skip_cnt = '0;
  logic [15:0] last_px = '0;
  logic [15:0] last_py = '0;
  logic [15:0] jump_limit;
  logic [3:0]  skip_limit;

  // Wandering pen position for well-formed press runs
  logic [15:0] cur_x = 16'd2000;
  logic [15:0] cur_y = 16'd2000;

  touch_sample_jump_filter_queue dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Ring push; reports whether the oldest event was dropped
  function automatic logic [2:0] ring_push(logic [62:0] t, logic [15:0] x, logic [15:0] y,
                                           logic pressed);
    ring_time[wr_ptr] = t;
    ring_pos[wr_ptr] = {pressed, y, x};
    wr_ptr = (wr_ptr + 1) % RING_DEPTH;
    if (wr_ptr == rd_ptr) begin
      rd_ptr = (rd_ptr + 1) % RING_DEPTH;
      return tsjf_pkg::ST_DROPPED;
    end
    return tsjf_pkg::ST_QUEUED;
  endfunction

  function automatic logic [15:0] axis_dist(logic [15:0] a, logic [15:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Expected result of one accepted word
  function automatic void filter_and_queue(tsjf_pkg::in_word_t w);
    tsjf_pkg::out_word_t r;
    logic                jump;
    r = '0;
    r.report_status = tsjf_pkg::ST_OTHER;
    if (w.opcode == tsjf_pkg::OP_REPORT) begin
      if (!w.stat_lo[7]) begin
        r.report_status = tsjf_pkg::ST_NOT_OURS;
      end else if (w.stat_lo[6:0] == tsjf_pkg::CODE_RELEASE &&
                   w.stat_hi == tsjf_pkg::HIGH_RELEASE) begin
        r.report_status = ring_push(w.timestamp, 16'd0, 16'd0, 1'b0);
      end else if (w.stat_lo[6:0] == tsjf_pkg::CODE_PRESS &&
                   w.stat_hi == tsjf_pkg::HIGH_PRESS) begin
        jump = axis_dist(w.sample_x, last_px) > jump_limit ||
               axis_dist(w.sample_y, last_py) > jump_limit;
        if (skip_cnt != 0 && skip_cnt <= skip_limit && jump) begin
          skip_cnt = skip_cnt + 4'd1;
          r.report_status = tsjf_pkg::ST_JUMP;
        end else begin
          skip_cnt = 4'd1;
          last_px = w.sample_x;
          last_py = w.sample_y;
          r.report_status = ring_push(w.timestamp, w.sample_x, w.sample_y, 1'b1);
        end
      end else begin
        r.report_status = tsjf_pkg::ST_BAD;
      end
    end else if (w.opcode == tsjf_pkg::OP_READ) begin
      if (rd_ptr != wr_ptr) begin
        r.event_valid   = 1'b1;
        r.event_time    = ring_time[rd_ptr];
        r.event_x       = ring_pos[rd_ptr][15:0];
        r.event_y       = ring_pos[rd_ptr][31:16];
        r.event_pressed = ring_pos[rd_ptr][32];
        rd_ptr = (rd_ptr + 1) % RING_DEPTH;
      end
    end else if (w.opcode == tsjf_pkg::OP_RELEASE) begin
      skip_cnt = 4'd0;
    end
    outcome_queue.push_back(r);
  endfunction

  // Driver: present the next pending word, hold it until taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        filter_and_queue(in_data);
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (touch_cmds.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_data  <= touch_cmds.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_outcome(tsjf_pkg::out_word_t got);
    tsjf_pkg::out_word_t exp;
    if (outcome_queue.size() == 0) begin
      $error("result word with nothing expected: %h", got);
      mismatch_count++;
      return;
    end
    exp = outcome_queue.pop_front();
    if (got.report_status !== exp.report_status) begin
      $error("report_status: expected %0d, actual %0d", exp.report_status, got.report_status);
      mismatch_count++;
    end
    if (got.event_valid !== exp.event_valid) begin
      $error("event_valid: expected %0d, actual %0d", exp.event_valid, got.event_valid);
      mismatch_count++;
    end
    if (got.event_time !== exp.event_time) begin
      $error("event_time: expected %0h, actual %0h", exp.event_time, got.event_time);
      mismatch_count++;
    end
    if (got.event_x !== exp.event_x) begin
      $error("event_x: expected %0h, actual %0h", exp.event_x, got.event_x);
      mismatch_count++;
    end
    if (got.event_y !== exp.event_y) begin
      $error("event_y: expected %0h, actual %0h", exp.event_y, got.event_y);
      mismatch_count++;
    end
    if (got.event_pressed !== exp.event_pressed) begin
      $error("event_pressed: expected %0d, actual %0d", exp.event_pressed, got.event_pressed);
      mismatch_count++;
    end
  endfunction

  // Monitor: take results with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_outcome(out_data);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [62:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[62:0];
  endfunction

  function automatic tsjf_pkg::in_word_t make_word(logic [1:0] op, logic [7:0] sl,
                                                   logic [7:0] sh, logic [15:0] x,
                                                   logic [15:0] y, logic [62:0] t);
    tsjf_pkg::in_word_t w;
    w.opcode = op;
    w.stat_lo = sl;
    w.stat_hi = sh;
    w.sample_x = x;
    w.sample_y = y;
    w.timestamp = t;
    return w;
  endfunction

  function automatic tsjf_pkg::in_word_t press_word(logic [15:0] x, logic [15:0] y);
    return make_word(tsjf_pkg::OP_REPORT, {1'b1, tsjf_pkg::CODE_PRESS}, tsjf_pkg::HIGH_PRESS,
                     x, y, rand_time());
  endfunction

  function automatic tsjf_pkg::in_word_t noise_word(logic [1:0] op, logic [7:0] sl,
                                                    logic [7:0] sh);
    return make_word(op, sl, sh, 16'($urandom), 16'($urandom), rand_time());
  endfunction

  task automatic queue_cmd(tsjf_pkg::in_word_t w);
    touch_cmds.push_back(w);
    queued_count++;
  endtask

  // Block goes idle once every word is taken and every result is back
  task automatic wait_idle();
    while (accepted_count != queued_count || outcome_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_filter(logic [15:0] delta, logic [3:0] skips);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= tsjf_pkg::CFG_JUMP_MAX;
    cfg_data  <= delta;
    @(posedge clk);
    cfg_index <= tsjf_pkg::CFG_SKIP_MAX;
    cfg_data  <= {12'd0, skips};
    @(posedge clk);
    cfg_we <= 1'b0;
    jump_limit = delta;
    skip_limit = skips;
  endtask

  // Press at the pen position, then a run of far samples to exercise the skip counter
  task automatic queue_jump_run();
    int n;
    int i;
    n = $urandom_range(20, 14);
    queue_cmd(press_word(cur_x, cur_y));
    for (i = 0; i < n; i++) begin
      if ($urandom_range(1))
        queue_cmd(press_word(cur_x ^ 16'h8000, cur_y ^ 16'($urandom_range(255))));
      else
        queue_cmd(press_word(cur_x ^ 16'($urandom_range(255)), cur_y ^ 16'h8000));
    end
  endtask

  // Mixed traffic; read share varies so the ring both fills up and runs empty
  task automatic queue_mixed_burst(int len);
    int read_pct;
    int i;
    int pick;
    case ($urandom_range(2))
      0: read_pct = 5;
      1: read_pct = 25;
      default: read_pct = 60;
    endcase
    for (i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < read_pct) begin
        queue_cmd(noise_word(tsjf_pkg::OP_READ, 8'($urandom), 8'($urandom)));
      end else begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          pick = $urandom_range(99);
          if (pick < 60) begin
            cur_x = cur_x + 16'($urandom_range(1200)) - 16'd600;
            cur_y = cur_y + 16'($urandom_range(1200)) - 16'd600;
          end else if (pick < 90) begin
            cur_x = 16'($urandom);
            cur_y = 16'($urandom);
          end else begin
            cur_x = $urandom_range(1) ? 16'hffff : 16'h0000;
            cur_y = $urandom_range(1) ? 16'hffff : 16'h0000;
          end
          queue_cmd(press_word(cur_x, cur_y));
        end else if (pick < 70) begin
          queue_cmd(noise_word(tsjf_pkg::OP_REPORT, {1'b1, tsjf_pkg::CODE_RELEASE},
                               tsjf_pkg::HIGH_RELEASE));
        end else if (pick < 78) begin
          queue_cmd(noise_word(tsjf_pkg::OP_RELEASE, 8'($urandom), 8'($urandom)));
        end else if (pick < 84) begin
          queue_cmd(noise_word(tsjf_pkg::OP_REPORT, {1'b0, 7'($urandom)}, 8'($urandom)));
        end else if (pick < 93) begin
          queue_cmd(noise_word(tsjf_pkg::OP_REPORT, {1'b1, 7'($urandom)}, 8'($urandom)));
        end else begin
          queue_cmd(noise_word(tsjf_pkg::OP_SPARE, 8'($urandom), 8'($urandom)));
        end
      end
    end
  endtask

  task automatic run_phase(logic [15:0] delta, logic [3:0] skips, int n);
    int start;
    wait_idle();
    set_filter(delta, skips);
    start = queued_count;
    while (queued_count - start < n) begin
      if ($urandom_range(99) < 15)
        queue_jump_run();
      else
        queue_mixed_burst(30);
    end
  endtask

  initial begin
    jump_limit = tsjf_pkg::JUMP_MAX_RST;
    skip_limit = tsjf_pkg::SKIP_MAX_RST;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty read, release, skip filter at reset settings, bad codes, drain
    queue_cmd(make_word(tsjf_pkg::OP_READ, 8'h00, 8'h00, 16'h0000, 16'h0000, 63'd0));
    queue_cmd(make_word(tsjf_pkg::OP_REPORT, {1'b1, tsjf_pkg::CODE_RELEASE},
                        tsjf_pkg::HIGH_RELEASE, 16'hffff, 16'hffff, {63{1'b1}}));
    queue_cmd(make_word(tsjf_pkg::OP_REPORT, {1'b1, tsjf_pkg::CODE_PRESS},
                        tsjf_pkg::HIGH_PRESS, 16'h0000, 16'h0000, 63'd0));
    queue_cmd(press_word(16'hffff, 16'hffff));
    queue_cmd(press_word(16'hffff, 16'h0000));
    queue_cmd(press_word(16'h0000, 16'hffff));
    queue_cmd(press_word(16'hffff, 16'hffff));
    queue_cmd(press_word(16'hfc7b, 16'hffff));
    queue_cmd(make_word(tsjf_pkg::OP_RELEASE, 8'hff, 8'hff, 16'hffff, 16'hffff,
                        {63{1'b1}}));
    queue_cmd(press_word(16'h0000, 16'h0000));
    queue_cmd(make_word(tsjf_pkg::OP_SPARE, 8'hff, 8'hff, 16'hffff, 16'hffff, {63{1'b1}}));
    queue_cmd(noise_word(tsjf_pkg::OP_REPORT, {1'b0, tsjf_pkg::CODE_PRESS},
                         tsjf_pkg::HIGH_PRESS));
    queue_cmd(noise_word(tsjf_pkg::OP_REPORT, 8'h7f, 8'h0c));
    queue_cmd(noise_word(tsjf_pkg::OP_REPORT, {1'b1, tsjf_pkg::CODE_PRESS}, 8'h0d));
    queue_cmd(noise_word(tsjf_pkg::OP_REPORT, 8'h81, 8'h00));
    queue_cmd(noise_word(tsjf_pkg::OP_REPORT, 8'hff, 8'hff));
    repeat (7) queue_cmd(noise_word(tsjf_pkg::OP_READ, 8'($urandom), 8'($urandom)));

    // Random phases across filter settings and idle patterns
    run_phase(16'd0, 4'd14, 280);
    run_phase(16'hffff, 4'd0, 250);
    send_gap_pct = 57;
    recv_stall_pct = 11;
    run_phase(16'd2000, 4'd15, 280);
    run_phase(16'd500, 4'd1, 280);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    run_phase(tsjf_pkg::JUMP_MAX_RST, tsjf_pkg::SKIP_MAX_RST, 280);
    run_phase(16'($urandom), 4'($urandom), 280);

    wait_idle();
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

### touch_sample_jump_filter_queue.f
rtl/tsjf_pkg.sv
rtl/tsjf_front.sv
rtl/tsjf_cmd_fifo.sv
rtl/tsjf_back.sv
rtl/touch_sample_jump_filter_queue.sv
rtl/tsjf_checker.sv
tb/sv/touch_sample_jump_filter_queue_tb.sv
